### hw/rtl/slcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shuffled LCG package
// Widths, register indexes, reset values and command codes that are shared by
// the interfaces, the divider and the top level.
// ----------------------------------------------------------------------------
package slcg_pkg;

	localparam int VALUE_WIDTH = 24;
	localparam int MOD_W       = VALUE_WIDTH + 1;
	localparam int SEED_W      = 32;
	localparam int DIFF_W      = SEED_W + 2;

	// Dividend width covers multiplier * state + increment and the seed magnitude.
	localparam int DIV_W       = (2 * VALUE_WIDTH > DIFF_W) ? 2 * VALUE_WIDTH : DIFF_W;
	localparam int DIV_STEPS   = DIV_W / 2;
	localparam int REM_W       = VALUE_WIDTH + 2;

	localparam int CFG_W       = MOD_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd2;

	localparam logic [MOD_W-1:0]       MOD_RESET = 25'd714025;
	localparam logic [VALUE_WIDTH-1:0] MUL_RESET = 24'd1366;
	localparam logic [VALUE_WIDTH-1:0] INC_RESET = 24'd150889;

	localparam logic [MOD_W-1:0] MOD_MIN = 25'd2;
	localparam logic [MOD_W-1:0] MOD_CAP = 25'd1 << VALUE_WIDTH;

	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'd1;

endpackage

### hw/rtl/slcg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shuffled LCG stream interfaces
// Command channel (command, seed) and result channel (drawn value), each a
// valid/ready stream with a source and a sink modport.
// ----------------------------------------------------------------------------
interface slcg_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic signed [slcg_pkg::SEED_W-1:0] seed_value;

	modport source (output valid, output command, output seed_value, input ready);
	modport sink (input valid, input command, input seed_value, output ready);
endinterface

interface slcg_val_if;
	logic                             valid;
	logic                             ready;
	logic [slcg_pkg::VALUE_WIDTH-1:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

### hw/rtl/slcg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module slcg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 97
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/slcg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-4 restoring divider
// Unsigned divide of a DIV_W-bit dividend by the effective modulus, two
// quotient bits per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module slcg_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [slcg_pkg::DIV_W-1:0]       dividend,
	input  logic [slcg_pkg::MOD_W-1:0]       divisor,
	output logic                             done,
	output logic [slcg_pkg::DIV_W-1:0]       quotient,
	output logic [slcg_pkg::VALUE_WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(slcg_pkg::DIV_STEPS);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [slcg_pkg::DIV_W-1:0]   dvd_q;
	logic [slcg_pkg::REM_W-1:0]   rem_q;
	logic [slcg_pkg::REM_W-1:0]   dsr_q;

	logic [slcg_pkg::REM_W-1:0]   r1, r1_sub, r2, r2_sub;
	logic                         ge1, ge2;

	// Two dependent shift-compare-subtract steps per cycle.
	always_comb begin
		r1     = {rem_q[slcg_pkg::REM_W-2:0], dvd_q[slcg_pkg::DIV_W-1]};
		ge1    = (r1 >= dsr_q);
		r1_sub = ge1 ? (r1 - dsr_q) : r1;
		r2     = {r1_sub[slcg_pkg::REM_W-2:0], dvd_q[slcg_pkg::DIV_W-2]};
		ge2    = (r2 >= dsr_q);
		r2_sub = ge2 ? (r2 - dsr_q) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(slcg_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= slcg_pkg::REM_W'(divisor);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[slcg_pkg::DIV_W-3:0], ge1, ge2};
			rem_q <= r2_sub;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q[slcg_pkg::VALUE_WIDTH-1:0];

endmodule

### hw/rtl/shuffled_lcg_random_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shuffled LCG random generator
// Linear congruential generator behind a shuffle table held in a RAM; every
// modulo and the table index go through one shared two-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// A draw with a filled table runs from command beat to result beat through two
// divider passes (the table index, then the next LCG step) plus the table read.
// A seed adds a divider pass for the seed modulo and one per table entry, plus one.
// One command is worked at a time; the next is taken while a result waits.
// Reset puts the configuration at its defaults and marks the table unfilled,
// so the first draw seeds with 1. The table RAM itself is not cleared.
module shuffled_lcg_random_generator_top #(
	parameter int TABLE_SIZE = 97
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [slcg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [slcg_pkg::CFG_W-1:0]      wr_data,
	slcg_cmd_if.sink                        cmd,
	slcg_val_if.source                      rsp
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int VW = slcg_pkg::VALUE_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_START,
		ST_SEED_DIV,
		ST_FILL_MUL,
		ST_STEP_START,
		ST_STEP_DIV,
		ST_IDX_START,
		ST_IDX_DIV,
		ST_READ,
		ST_RDATA,
		ST_OUT
	} state_t;

	// Configuration registers.
	logic [slcg_pkg::MOD_W-1:0] mod_q;
	logic [VW-1:0]              mul_q;
	logic [VW-1:0]              inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= slcg_pkg::MOD_RESET;
			mul_q <= slcg_pkg::MUL_RESET;
			inc_q <= slcg_pkg::INC_RESET;
		end else if (wr_en) begin
			case (wr_index)
				slcg_pkg::REG_MODULUS:    mod_q <= wr_data;
				slcg_pkg::REG_MULTIPLIER: mul_q <= wr_data[VW-1:0];
				slcg_pkg::REG_INCREMENT:  inc_q <= wr_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// Modulus clamped so that every value fits the output width.
	logic [slcg_pkg::MOD_W-1:0] mod_eff;
	always_comb begin
		if (mod_q < slcg_pkg::MOD_MIN) begin
			mod_eff = slcg_pkg::MOD_MIN;
		end else if (mod_q > slcg_pkg::MOD_CAP) begin
			mod_eff = slcg_pkg::MOD_CAP;
		end else begin
			mod_eff = mod_q;
		end
	end

	state_t                  state_q;
	logic                    drawing_q;
	logic                    ready_q;
	logic [CW-1:0]           cnt_q;
	logic [VW-1:0]           lcg_q;
	logic [VW-1:0]           last_q;
	logic                    out_valid_q;
	logic [VW-1:0]           out_data_q;

	logic [slcg_pkg::DIFF_W-1:0] diff_q;
	logic [slcg_pkg::DIV_W-1:0]  prod_q;
	logic [AW-1:0]               idx_q;
	logic [VW-1:0]               val_q;

	logic                        accept;
	logic                        seeding;
	logic [slcg_pkg::SEED_W-1:0] seed_sel;
	logic [slcg_pkg::DIFF_W-1:0] diff_next;
	logic [slcg_pkg::DIFF_W-1:0] diff_abs;
	logic [slcg_pkg::DIV_W-1:0]  prod_next;
	logic                        out_load;
	logic                        fill_more;

	logic                        div_start;
	logic [slcg_pkg::DIV_W-1:0]  div_dividend;
	logic                        div_done;
	logic [slcg_pkg::DIV_W-1:0]  div_quot;
	logic [VW-1:0]               div_rem;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic                        ram_re;
	logic [VW-1:0]               ram_rdata;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign seeding   = (cmd.command == slcg_pkg::CMD_SEED) || !ready_q;
	assign seed_sel  = (cmd.command == slcg_pkg::CMD_SEED) ? cmd.seed_value
	                                                       : slcg_pkg::DEFAULT_SEED;

	// Seed distance as a two's complement value; its magnitude is taken mod m,
	// which matches the magnitude of a truncating remainder.
	assign diff_next = slcg_pkg::DIFF_W'(inc_q)
	                 - {{(slcg_pkg::DIFF_W - slcg_pkg::SEED_W){seed_sel[slcg_pkg::SEED_W-1]}},
	                    seed_sel};
	assign diff_abs  = diff_q[slcg_pkg::DIFF_W-1] ? (~diff_q + 1'b1) : diff_q;

	assign prod_next = (slcg_pkg::DIV_W'(mul_q) * slcg_pkg::DIV_W'(lcg_q))
	                 + slcg_pkg::DIV_W'(inc_q);

	assign fill_more = (cnt_q < CW'(TABLE_SIZE));
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	assign div_start = (state_q == ST_SEED_START) || (state_q == ST_STEP_START)
	                || (state_q == ST_IDX_START);

	always_comb begin
		case (state_q)
			ST_SEED_START: div_dividend = slcg_pkg::DIV_W'(diff_abs);
			ST_IDX_START:  div_dividend = slcg_pkg::DIV_W'(last_q)
			                            * slcg_pkg::DIV_W'(TABLE_SIZE);
			default:       div_dividend = prod_q;
		endcase
	end

	slcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (mod_eff),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign ram_we    = (state_q == ST_STEP_DIV) && div_done && (drawing_q || fill_more);
	assign ram_waddr = drawing_q ? idx_q : cnt_q[AW-1:0];
	assign ram_re    = (state_q == ST_READ);

	slcg_ram #(
		.WIDTH (VW),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (div_rem),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drawing_q   <= 1'b0;
			ready_q     <= 1'b0;
			cnt_q       <= '0;
			lcg_q       <= VW'(1);
			last_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= val_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= seeding ? ST_SEED_START : ST_IDX_START;
					end
				end
				ST_SEED_START: state_q <= ST_SEED_DIV;
				ST_SEED_DIV: begin
					if (div_done) begin
						lcg_q   <= div_rem;
						cnt_q   <= '0;
						state_q <= ST_FILL_MUL;
					end
				end
				ST_FILL_MUL:   state_q <= ST_STEP_START;
				ST_STEP_START: state_q <= ST_STEP_DIV;
				ST_STEP_DIV: begin
					if (div_done) begin
						lcg_q <= div_rem;
						if (drawing_q) begin
							last_q  <= val_q;
							state_q <= ST_OUT;
						end else if (fill_more) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_FILL_MUL;
						end else begin
							// One value past the table becomes the last output.
							last_q  <= div_rem;
							ready_q <= 1'b1;
							state_q <= ST_IDX_START;
						end
					end
				end
				ST_IDX_START:  state_q <= ST_IDX_DIV;
				ST_IDX_DIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					drawing_q <= 1'b1;
					state_q   <= ST_RDATA;
				end
				ST_RDATA:      state_q <= ST_STEP_START;
				ST_OUT: begin
					if (out_load) begin
						drawing_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default:       state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= diff_next;
		end
		if ((state_q == ST_FILL_MUL) || (state_q == ST_RDATA)) begin
			prod_q <= prod_next;
		end
		if ((state_q == ST_IDX_DIV) && div_done) begin
			// A stale last output at or above the modulus saturates the index.
			idx_q <= (div_quot > slcg_pkg::DIV_W'(TABLE_SIZE - 1)) ? AW'(TABLE_SIZE - 1)
			                                                        : div_quot[AW-1:0];
		end
		if (state_q == ST_RDATA) begin
			val_q <= ram_rdata;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_data_q;

endmodule
